### rtl/core/dvrgb_pkg.sv
// ----------------------------------------------------------------------------
// dvrgb_pkg
// Shared constants and tables for the direction vector color pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package dvrgb_pkg;

  localparam int CW_DEF       = 24;  // component width
  localparam int AFB_DEF      = 8;   // angle fraction bits
  localparam int ACC_BITS     = 24;  // cordic angle fraction bits
  localparam int CORDIC_STEPS = 28;
  localparam int MAG_W        = 32;  // magnitude width into a cordic
  localparam int NORM_MSB     = 40;  // cordic operands normalized to [2^40, 2^41)
  localparam int CORDIC_XW    = 46;
  localparam int CORDIC_ZW    = 33;
  localparam int ANG_W        = 31;  // clamped angle, 0..90 deg, ACC_BITS fraction
  localparam int SC_MSB       = 29;  // plunge operands scaled to [2^29, 2^30)
  localparam int SC_W         = 30;
  localparam int SQRT_STEPS   = 32;
  localparam int RAD_W        = 64;
  localparam int ROOT_W       = 32;

  // pipeline depths
  localparam int CORDIC_LAT = CORDIC_STEPS + 3;
  localparam int SCALE_LAT  = 4;
  localparam int CHAN_LAT   = 3;

  localparam logic [ANG_W-1:0] ANG_TOP = ANG_W'(90) << ACC_BITS;
  localparam logic [33:0]      HALF_TURN = 34'd180 << ACC_BITS;

  // atan(2^-i) in degrees, ACC_BITS fraction bits
  localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
    32'd754974720, 32'd445687602, 32'd235489088, 32'd119537938, 32'd60000934,
    32'd30029717,  32'd15018523,  32'd7509720,   32'd3754917,   32'd1877466,
    32'd938734,    32'd469367,    32'd234684,    32'd117342,    32'd58671,
    32'd29335,     32'd14668,     32'd7334,      32'd3667,      32'd1833,
    32'd917,       32'd458,       32'd229,       32'd115,       32'd57,
    32'd29,        32'd14,        32'd7
  };

endpackage

`default_nettype wire

### rtl/core/direction_vector_to_rgb.sv
// ----------------------------------------------------------------------------
// direction_vector_to_rgb
// Maps a 3D direction vector to an RGB color from its trend and plunge.
// ----------------------------------------------------------------------------
// Input: pulse start with in_vec_x/y/z and in_mask_bit; the item is taken at
// any edge where start is high and busy is low. busy stays low, so a new
// vector can be started on every clock cycle.
// Output: out_valid is high for one cycle with out_red/green/blue; the
// receiver must take it then. Results leave in start order.
// Pipeline: one result per cycle sustained. The depth is set by the plunge
// path: scaling and squaring, a 32-cell square root chain, a 31-stage cordic,
// then the angle, hue and 3-stage channel blend stages. Trend runs in a
// parallel cordic and is delayed to match.
// Config: cfg_use_mask is written by a cfg_valid transfer (cfg_ready is always
// high); write it only while no item is in flight.
// Reset: synchronous rst_n clears use_mask and all valid flags; items in
// flight are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module direction_vector_to_rgb
  import dvrgb_pkg::*;
#(
  parameter int COMPONENT_WIDTH     = CW_DEF,
  parameter int ANGLE_FRACTION_BITS = AFB_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [COMPONENT_WIDTH-1:0] in_vec_x,
  input  logic signed [COMPONENT_WIDTH-1:0] in_vec_y,
  input  logic signed [COMPONENT_WIDTH-1:0] in_vec_z,
  input  logic                              in_mask_bit,
  output logic                              out_valid,
  output logic [7:0]                        out_red,
  output logic [7:0]                        out_green,
  output logic [7:0]                        out_blue,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic                              cfg_use_mask
);

  localparam int CW  = COMPONENT_WIDTH;
  localparam int F   = ANGLE_FRACTION_BITS;
  localparam int AW  = F + 7;
  localparam int TW  = F + 9;
  localparam int RS  = ACC_BITS - F;
  localparam int ANG_DLY  = SCALE_LAT + SQRT_STEPS + CORDIC_LAT;
  localparam int TR_DLY   = SCALE_LAT + SQRT_STEPS;
  localparam int LAT_OUT  = ANG_DLY + CHAN_LAT + 4;
  localparam logic [TW-1:0] FULL_T  = TW'(360) << F;
  localparam logic [AW-1:0] QUART_T = AW'(90) << F;
  localparam logic [AW-1:0] WFULL   = AW'(120) << F;
  localparam logic [33:0]   RBIAS   = 34'd1 << (RS - 1);

  // ---------------- config and input stage ----------------
  logic use_mask_r;
  logic acc;
  logic [CW-1:0] mx, my, mz;
  logic a_valid_r, a_kill_r, a_nx_r, a_ny_r, a_pzero_r;
  logic [CW-1:0] a_ax_r, a_ay_r, a_az_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign acc       = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_mask_r <= 1'b0;
      a_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) use_mask_r <= cfg_use_mask;
      a_valid_r <= acc;
    end
  end

  always_comb begin
    mx = in_vec_x[CW-1] ? (~$unsigned(in_vec_x) + 1'b1) : $unsigned(in_vec_x);
    my = in_vec_y[CW-1] ? (~$unsigned(in_vec_y) + 1'b1) : $unsigned(in_vec_y);
    mz = in_vec_z[CW-1] ? (~$unsigned(in_vec_z) + 1'b1) : $unsigned(in_vec_z);
  end

  always_ff @(posedge clk) begin
    a_ax_r    <= mx;
    a_ay_r    <= my;
    a_az_r    <= mz;
    // negative z flips the vector into the upper hemisphere
    a_nx_r    <= in_vec_x[CW-1] ^ in_vec_z[CW-1];
    a_ny_r    <= in_vec_y[CW-1] ^ in_vec_z[CW-1];
    a_kill_r  <= use_mask_r && !in_mask_bit;
    a_pzero_r <= (mx == '0) && (my == '0) && (mz == '0);
  end

  // ---------------- trend cordic ----------------
  logic [ANG_W-1:0] tr_ang, tr_ang_d;

  dvrgb_cordic u_trend (
    .clk   (clk),
    .rst_n (rst_n),
    .in_a  (MAG_W'(a_ax_r)),
    .in_b  (MAG_W'(a_ay_r)),
    .angle (tr_ang)
  );

  dvrgb_delay #(.WIDTH(ANG_W), .DEPTH(TR_DLY)) u_tr_dly (
    .clk   (clk),
    .rst_n (rst_n),
    .d_in  (tr_ang),
    .d_out (tr_ang_d)
  );

  // ---------------- plunge scaling ----------------
  logic [CW-1:0] m3;
  logic [4:0]    p3;
  logic [CW-1:0] s1_ax_r, s1_ay_r, s1_az_r;
  logic [4:0]    s1_lsh_r, s1_lsh_nxt;
  logic [1:0]    s1_rsh_r, s1_rsh_nxt;
  logic [SC_W-1:0]   s2_x_r, s2_y_r, s2_z_r, s3_z_r, s4_z_r;
  logic [2*SC_W-1:0] s3_xx_r, s3_yy_r;
  logic [RAD_W-1:0]  s4_sum_r;

  always_comb begin
    m3 = (a_ax_r > a_ay_r) ? a_ax_r : a_ay_r;
    if (a_az_r > m3) m3 = a_az_r;
    p3 = '0;
    for (int i = 0; i < CW; i++) begin
      if (m3[i]) p3 = 5'(i);
    end
    s1_lsh_nxt = (p3 < 5'(SC_MSB)) ? 5'(SC_MSB) - p3 : 5'd0;
    s1_rsh_nxt = (p3 > 5'(SC_MSB)) ? 2'(p3 - 5'(SC_MSB)) : 2'd0;
  end

  always_ff @(posedge clk) begin
    s1_ax_r  <= a_ax_r;
    s1_ay_r  <= a_ay_r;
    s1_az_r  <= a_az_r;
    s1_lsh_r <= s1_lsh_nxt;
    s1_rsh_r <= s1_rsh_nxt;
    s2_x_r   <= SC_W'((RAD_W'(s1_ax_r) << s1_lsh_r) >> s1_rsh_r);
    s2_y_r   <= SC_W'((RAD_W'(s1_ay_r) << s1_lsh_r) >> s1_rsh_r);
    s2_z_r   <= SC_W'((RAD_W'(s1_az_r) << s1_lsh_r) >> s1_rsh_r);
    s3_xx_r  <= (2*SC_W)'(s2_x_r) * (2*SC_W)'(s2_x_r);
    s3_yy_r  <= (2*SC_W)'(s2_y_r) * (2*SC_W)'(s2_y_r);
    s3_z_r   <= s2_z_r;
    s4_sum_r <= RAD_W'(s3_xx_r) + RAD_W'(s3_yy_r);
    s4_z_r   <= s3_z_r;
  end

  // ---------------- horizontal length ----------------
  logic [RAD_W-1:0] sq_v   [SQRT_STEPS+1];
  logic [RAD_W-1:0] sq_res [SQRT_STEPS+1];
  logic [SC_W-1:0]  sz_d;

  assign sq_v[0]   = s4_sum_r;
  assign sq_res[0] = '0;

  for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
    dvrgb_isqrt_cell #(.IDX(g)) u_cell (
      .clk     (clk),
      .v_in    (sq_v[g]),
      .res_in  (sq_res[g]),
      .v_out   (sq_v[g+1]),
      .res_out (sq_res[g+1])
    );
  end

  dvrgb_delay #(.WIDTH(SC_W), .DEPTH(SQRT_STEPS)) u_sz_dly (
    .clk   (clk),
    .rst_n (rst_n),
    .d_in  (s4_z_r),
    .d_out (sz_d)
  );

  // ---------------- plunge cordic ----------------
  logic [ANG_W-1:0] pl_ang;

  dvrgb_cordic u_plunge (
    .clk   (clk),
    .rst_n (rst_n),
    .in_a  (MAG_W'(sz_d)),
    .in_b  (sq_res[SQRT_STEPS][ROOT_W-1:0]),
    .angle (pl_ang)
  );

  // side data carried to the angle stage
  logic [4:0] side_in, side_d;
  logic       d_valid, d_kill, d_nx, d_ny, d_pzero;

  assign side_in = {a_valid_r, a_kill_r, a_nx_r, a_ny_r, a_pzero_r};

  dvrgb_delay #(.WIDTH(5), .DEPTH(ANG_DLY)) u_side_dly (
    .clk   (clk),
    .rst_n (rst_n),
    .d_in  (side_in),
    .d_out (side_d)
  );

  assign {d_valid, d_kill, d_nx, d_ny, d_pzero} = side_d;

  // ---------------- angle stage ----------------
  logic [33:0]   tsum, tround, pround;
  logic [TW-1:0] trend_r, trend_nxt;
  logic [AW-1:0] plunge_r, plunge_nxt;
  logic          ang_valid_r, ang_kill_r;

  always_comb begin
    case ({d_nx, d_ny})
      2'b00:   tsum = 34'(tr_ang_d);
      2'b10:   tsum = HALF_TURN - 34'(tr_ang_d);
      2'b11:   tsum = HALF_TURN + 34'(tr_ang_d);
      default: tsum = (HALF_TURN << 1) - 34'(tr_ang_d);
    endcase
    tround    = (tsum + RBIAS) >> RS;
    trend_nxt = tround[TW-1:0];
    // full turn wraps to zero
    if (trend_nxt >= FULL_T) trend_nxt = trend_nxt - FULL_T;
    pround     = (34'(pl_ang) + RBIAS) >> RS;
    plunge_nxt = d_pzero ? QUART_T : pround[AW-1:0];
  end

  always_ff @(posedge clk) begin
    trend_r  <= trend_nxt;
    plunge_r <= plunge_nxt;
  end

  // ---------------- hue weights ----------------
  logic [TW-1:0] u1, u2;
  logic [AW-1:0] wr_r, wg_r, wb_r, wr_nxt, wg_nxt, wb_nxt, pw_r;
  logic          wgt_valid_r, wgt_kill_r;

  always_comb begin
    u1 = trend_r - TW'(WFULL);
    u2 = trend_r - (TW'(WFULL) << 1);
    if (trend_r <= TW'(WFULL)) begin
      wr_nxt = WFULL - trend_r[AW-1:0];
      wg_nxt = trend_r[AW-1:0];
      wb_nxt = '0;
    end else if (trend_r <= (TW'(WFULL) << 1)) begin
      wr_nxt = '0;
      wg_nxt = WFULL - u1[AW-1:0];
      wb_nxt = u1[AW-1:0];
    end else begin
      wr_nxt = u2[AW-1:0];
      wg_nxt = '0;
      wb_nxt = WFULL - u2[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    wr_r <= wr_nxt;
    wg_r <= wg_nxt;
    wb_r <= wb_nxt;
    pw_r <= plunge_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ang_valid_r <= 1'b0;
      ang_kill_r  <= 1'b0;
      wgt_valid_r <= 1'b0;
      wgt_kill_r  <= 1'b0;
    end else begin
      ang_valid_r <= d_valid;
      ang_kill_r  <= d_kill;
      wgt_valid_r <= ang_valid_r;
      wgt_kill_r  <= ang_kill_r;
    end
  end

  // ---------------- channels ----------------
  logic [7:0] sh_r, sh_g, sh_b;

  dvrgb_chan #(.ANGLE_FRACTION_BITS(F)) u_red (
    .clk (clk), .weight (wr_r), .plunge (pw_r), .shade (sh_r)
  );
  dvrgb_chan #(.ANGLE_FRACTION_BITS(F)) u_green (
    .clk (clk), .weight (wg_r), .plunge (pw_r), .shade (sh_g)
  );
  dvrgb_chan #(.ANGLE_FRACTION_BITS(F)) u_blue (
    .clk (clk), .weight (wb_r), .plunge (pw_r), .shade (sh_b)
  );

  logic [1:0] fin_d;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] red_r, green_r, blue_r;

  dvrgb_delay #(.WIDTH(2), .DEPTH(CHAN_LAT)) u_fin_dly (
    .clk   (clk),
    .rst_n (rst_n),
    .d_in  ({wgt_valid_r, wgt_kill_r}),
    .d_out (fin_d)
  );

  assign out_valid_nxt = fin_d[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // masked items come out black
  always_ff @(posedge clk) begin
    red_r   <= fin_d[0] ? 8'd0 : sh_r;
    green_r <= fin_d[0] ? 8'd0 : sh_g;
    blue_r  <= fin_d[0] ? 8'd0 : sh_b;
  end

  assign out_valid = out_valid_r;
  assign out_red   = red_r;
  assign out_green = green_r;
  assign out_blue  = blue_r;

  // ---------------- checks ----------------
  a_trend_range: assert property (@(posedge clk) disable iff (!rst_n)
    ang_valid_r |-> (trend_r < FULL_T))
    else $error("trend out of range");

  a_plunge_range: assert property (@(posedge clk) disable iff (!rst_n)
    ang_valid_r |-> (plunge_r <= QUART_T))
    else $error("plunge above quarter turn");

  a_weight_sum: assert property (@(posedge clk) disable iff (!rst_n)
    wgt_valid_r |-> ((TW'(wr_r) + TW'(wg_r) + TW'(wb_r)) == TW'(WFULL)))
    else $error("hue weights do not sum to one sector");

  a_out_origin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy && rst_n, LAT_OUT))
    else $error("result without matching start transfer");

endmodule

`default_nettype wire

### rtl/core/dvrgb_delay.sv
// ----------------------------------------------------------------------------
// dvrgb_delay
// Fixed-depth shift line that keeps side data aligned with the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module dvrgb_delay #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [WIDTH-1:0] d_in,
  output logic [WIDTH-1:0] d_out
);

  logic [WIDTH-1:0] pipe_r [DEPTH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) pipe_r[i] <= '0;
    end else begin
      pipe_r[0] <= d_in;
      for (int i = 1; i < DEPTH; i++) pipe_r[i] <= pipe_r[i-1];
    end
  end

  assign d_out = pipe_r[DEPTH-1];

endmodule

`default_nettype wire

### rtl/core/dvrgb_cordic_cell.sv
// ----------------------------------------------------------------------------
// dvrgb_cordic_cell
// One vectoring rotation of the cordic chain, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module dvrgb_cordic_cell
  import dvrgb_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic                        clk,
  input  logic signed [CORDIC_XW-1:0] x_in,
  input  logic signed [CORDIC_XW-1:0] y_in,
  input  logic signed [CORDIC_ZW-1:0] z_in,
  output logic signed [CORDIC_XW-1:0] x_out,
  output logic signed [CORDIC_XW-1:0] y_out,
  output logic signed [CORDIC_ZW-1:0] z_out
);

  localparam logic signed [CORDIC_ZW-1:0] ATAN = signed'({1'b0, ATAN_TAB[IDX]});

  logic signed [CORDIC_XW-1:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [CORDIC_ZW-1:0] z_r, z_nxt;
  logic signed [CORDIC_XW-1:0] dx, dy;

  always_comb begin
    dx = y_in >>> IDX;
    dy = x_in >>> IDX;
    if (!y_in[CORDIC_XW-1]) begin
      x_nxt = x_in + dx;
      y_nxt = y_in - dy;
      z_nxt = z_in + ATAN;
    end else begin
      x_nxt = x_in - dx;
      y_nxt = y_in + dy;
      z_nxt = z_in - ATAN;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
  end

  assign x_out = x_r;
  assign y_out = y_r;
  assign z_out = z_r;

endmodule

`default_nettype wire

### rtl/core/dvrgb_cordic.sv
// ----------------------------------------------------------------------------
// dvrgb_cordic
// First-quadrant atan2 in degrees: normalize, cell chain, clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module dvrgb_cordic
  import dvrgb_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [MAG_W-1:0] in_a,   // x operand
  input  logic [MAG_W-1:0] in_b,   // y operand
  output logic [ANG_W-1:0] angle
);

  logic [MAG_W-1:0] a1_r, b1_r, m1;
  logic [5:0]       sh1_r, sh1_nxt, p1;
  logic             zero1_r;
  logic signed [CORDIC_XW-1:0] xc [CORDIC_STEPS+1];
  logic signed [CORDIC_XW-1:0] yc [CORDIC_STEPS+1];
  logic signed [CORDIC_ZW-1:0] zc [CORDIC_STEPS+1];
  logic signed [CORDIC_XW-1:0] x2_r, y2_r;
  logic             zero_d;
  logic [ANG_W-1:0] angle_r, angle_nxt;
  logic signed [CORDIC_ZW-1:0] zf;

  // leading one of the larger operand
  always_comb begin
    m1 = (in_a > in_b) ? in_a : in_b;
    p1 = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (m1[i]) p1 = 6'(i);
    end
    sh1_nxt = 6'(NORM_MSB) - p1;
  end

  always_ff @(posedge clk) begin
    a1_r    <= in_a;
    b1_r    <= in_b;
    sh1_r   <= sh1_nxt;
    zero1_r <= (m1 == '0);
    x2_r    <= signed'(CORDIC_XW'(a1_r) << sh1_r);
    y2_r    <= signed'(CORDIC_XW'(b1_r) << sh1_r);
  end

  assign xc[0] = x2_r;
  assign yc[0] = y2_r;
  assign zc[0] = '0;

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
    dvrgb_cordic_cell #(.IDX(g)) u_cell (
      .clk   (clk),
      .x_in  (xc[g]),
      .y_in  (yc[g]),
      .z_in  (zc[g]),
      .x_out (xc[g+1]),
      .y_out (yc[g+1]),
      .z_out (zc[g+1])
    );
  end

  dvrgb_delay #(.WIDTH(1), .DEPTH(CORDIC_STEPS + 1)) u_zero_dly (
    .clk   (clk),
    .rst_n (rst_n),
    .d_in  (zero1_r),
    .d_out (zero_d)
  );

  always_comb begin
    zf = zc[CORDIC_STEPS];
    if (zero_d || zf[CORDIC_ZW-1]) begin
      angle_nxt = '0;
    end else if (zf > signed'(CORDIC_ZW'(ANG_TOP))) begin
      angle_nxt = ANG_TOP;
    end else begin
      angle_nxt = zf[ANG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    angle_r <= angle_nxt;
  end

  assign angle = angle_r;

endmodule

`default_nettype wire

### rtl/core/dvrgb_isqrt_cell.sv
// ----------------------------------------------------------------------------
// dvrgb_isqrt_cell
// One digit of the bitwise integer square root, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module dvrgb_isqrt_cell
  import dvrgb_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic             clk,
  input  logic [RAD_W-1:0] v_in,
  input  logic [RAD_W-1:0] res_in,
  output logic [RAD_W-1:0] v_out,
  output logic [RAD_W-1:0] res_out
);

  localparam logic [RAD_W-1:0] BIT = RAD_W'(1) << (62 - 2 * IDX);

  logic [RAD_W-1:0] v_r, v_nxt, res_r, res_nxt, trial;

  always_comb begin
    trial = res_in + BIT;
    if (v_in >= trial) begin
      v_nxt   = v_in - trial;
      res_nxt = (res_in >> 1) + BIT;
    end else begin
      v_nxt   = v_in;
      res_nxt = res_in >> 1;
    end
  end

  always_ff @(posedge clk) begin
    v_r   <= v_nxt;
    res_r <= res_nxt;
  end

  assign v_out   = v_r;
  assign res_out = res_r;

endmodule

`default_nettype wire

### rtl/core/dvrgb_chan.sv
// ----------------------------------------------------------------------------
// dvrgb_chan
// Blend toward white for one channel: product, then ceil divide by reciprocal.
// ----------------------------------------------------------------------------
`default_nettype none

module dvrgb_chan
  import dvrgb_pkg::*;
#(
  parameter int ANGLE_FRACTION_BITS = AFB_DEF
) (
  input  logic                           clk,
  input  logic [ANGLE_FRACTION_BITS+6:0] weight,
  input  logic [ANGLE_FRACTION_BITS+6:0] plunge,
  output logic [7:0]                     shade
);

  localparam int AW = ANGLE_FRACTION_BITS + 7;
  localparam int KW = AW + 8;
  localparam int NW = 22 + 2 * ANGLE_FRACTION_BITS;
  localparam logic [AW-1:0] WFULL = AW'(120) << ANGLE_FRACTION_BITS;
  localparam logic [NW-1:0] DEN   = NW'(10800) << (2 * ANGLE_FRACTION_BITS);
  // divisor is 675 << SH; the biased sum stays below 256 * 675 after the shift
  localparam int SH = 2 * ANGLE_FRACTION_BITS + 4;
  localparam int QW = 18;
  localparam int PW = QW + 19;
  localparam logic [18:0] RECIP = 19'd397683;  // ceil(2^28 / 675)

  logic [AW-1:0] d;
  logic [KW-1:0] k;
  logic [NW-1:0] prod_r, prod_nxt, sum_r;
  logic [QW-1:0] sq;
  logic [PW-1:0] qp;
  logic [7:0]    q_r;

  always_comb begin
    d        = WFULL - weight;
    k        = (KW'(d) << 8) - KW'(d);
    prod_nxt = NW'(k) * NW'(plunge);
  end

  always_comb begin
    sq = QW'(sum_r >> SH);
    qp = PW'(sq) * PW'(RECIP);
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    sum_r  <= prod_r + (DEN - NW'(1));  // ceil by floor of biased value
    q_r    <= qp[28 +: 8];
  end

  assign shade = 8'd255 - q_r;

endmodule

`default_nettype wire
